// ===== design/vmbd_pkg.sv =====
// vmbd_pkg.sv: shared types, register map and constants of the virtio-mmio register unit
`timescale 1ns / 1ps
package vmbd_pkg;

  // bus actions carried by an input item
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_POLL  = 2'd2,
    ACT_NONE  = 2'd3
  } vmbd_action_t;

  // fault codes of a result item
  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_LOAD  = 2'd1,
    FAULT_STORE = 2'd2
  } vmbd_fault_t;

  // access size code for a full word
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // default geometry
  localparam int VMBD_CONFIG_BYTES = 8;
  localparam logic [31:0] VMBD_QUEUE_MAX = 32'd8;

  // start of the device config window
  localparam logic [11:0] CFG_BASE = 12'h100;

  // word register offsets
  localparam logic [11:0] REG_MAGIC        = 12'h000;
  localparam logic [11:0] REG_VERSION      = 12'h004;
  localparam logic [11:0] REG_DEVICE_ID    = 12'h008;
  localparam logic [11:0] REG_VENDOR_ID    = 12'h00c;
  localparam logic [11:0] REG_DEV_FEATURES = 12'h010;
  localparam logic [11:0] REG_DRV_FEATURES = 12'h020;
  localparam logic [11:0] REG_QUEUE_MAX    = 12'h034;
  localparam logic [11:0] REG_QUEUE_PFN    = 12'h040;
  localparam logic [11:0] REG_QUEUE_NOTIFY = 12'h050;
  localparam logic [11:0] REG_INT_STATUS   = 12'h060;
  localparam logic [11:0] REG_INT_ACK      = 12'h064;
  localparam logic [11:0] REG_STATUS       = 12'h070;

  // read-only identification values
  localparam logic [31:0] MAGIC_VALUE   = 32'h74726976;
  localparam logic [31:0] VERSION_VALUE = 32'h1;
  localparam logic [31:0] DEVICE_ID     = 32'h2;
  localparam logic [31:0] VENDOR_ID     = 32'h554d4551;

  // decoded view of the item held in the input register
  typedef struct packed {
    logic        rd;       // register read
    logic        wr;       // register write
    logic        poll;     // interrupt poll
    logic        word_ok;  // legal word access below the config window
    logic        cfg_ok;   // in-range access to the config window
    vmbd_fault_t fault;
    logic [11:0] off;
    logic [11:0] cfg_idx;
  } vmbd_dec_t;

endpackage

// ===== design/vmbd_if.sv =====
// vmbd_if.sv: valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
interface vmbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] offset;
  logic [1:0]  access_size;
  logic [31:0] write_data;

  modport source (output valid, action, offset, access_size, write_data, input ready);
  modport sink   (input valid, action, offset, access_size, write_data, output ready);
endinterface

interface vmbd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  fault;
  logic        irq_raised;

  modport source (output valid, read_data, fault, irq_raised, input ready);
  modport sink   (input valid, read_data, fault, irq_raised, output ready);
endinterface

// ===== design/vmbd_decode.sv =====
// vmbd_decode.sv: address and access decode of one bus item
`timescale 1ns / 1ps
module vmbd_decode import vmbd_pkg::*; #(
  parameter int CONFIG_BYTES = VMBD_CONFIG_BYTES
) (
  input  logic [1:0]  action,
  input  logic [11:0] offset,
  input  logic [1:0]  access_size,
  output vmbd_dec_t   dec
);

  vmbd_action_t act;
  logic         access;
  logic         in_cfg;
  logic         cfg_in_range;
  logic [11:0]  idx;

  // window split and range check
  assign act          = vmbd_action_t'(action);
  assign access       = (act == ACT_READ) || (act == ACT_WRITE);
  assign in_cfg       = |offset[11:8];
  assign idx          = offset - CFG_BASE;
  assign cfg_in_range = idx < 12'(CONFIG_BYTES);

  always_comb begin
    dec         = '0;
    dec.rd      = (act == ACT_READ);
    dec.wr      = (act == ACT_WRITE);
    dec.poll    = (act == ACT_POLL);
    dec.off     = offset;
    dec.cfg_idx = idx;
    dec.fault   = FAULT_OK;
    // config window takes any size, registers only full words
    if (access) begin
      if (in_cfg) begin
        dec.cfg_ok = cfg_in_range;
      end else begin
        dec.word_ok = (access_size == SIZE_WORD);
      end
      if (!dec.cfg_ok && !dec.word_ok) begin
        dec.fault = dec.wr ? FAULT_STORE : FAULT_LOAD;
      end
    end
  end

endmodule

// ===== design/vmbd_regs.sv =====
// vmbd_regs.sv: device registers, config byte memory and read data select
`timescale 1ns / 1ps
module vmbd_regs import vmbd_pkg::*; #(
  parameter int CONFIG_BYTES = VMBD_CONFIG_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_req,      // item enters the input register
  input  logic [11:0] rd_offset,   // its offset, for the config read
  input  logic        en,          // item in the input register is processed
  input  vmbd_dec_t   dec,
  input  logic [31:0] write_data,
  output logic [31:0] read_data,
  output logic        irq_raised
);

  localparam int IDX_W     = (CONFIG_BYTES > 1) ? $clog2(CONFIG_BYTES) : 1;
  localparam int CFG_DEPTH = 1 << IDX_W;

  logic [31:0] drv_feat_r;
  logic [31:0] qpfn_r;
  logic [31:0] dev_status_r;
  logic        pend_r;
  logic [7:0]  int_status_r;

  logic [7:0]  cfg_mem [CFG_DEPTH];
  logic [CFG_DEPTH-1:0] cfg_vld_r;
  logic [7:0]  mem_q_r;
  logic        byp_r;
  logic [7:0]  byp_data_r;
  logic        vld_hit_r;
  logic        rst_one_r;

  logic [IDX_W-1:0] widx;
  logic [IDX_W-1:0] ridx;
  logic [11:0]      rd_idx_full;
  logic [7:0]       wbyte;
  logic             cfg_wr;
  logic             word_wr;
  logic             poll_hit;
  logic [7:0]       cfg_byte;
  logic [31:0]      word_rd;

  // byte lane of the write data picked by the low offset bits
  assign widx        = dec.cfg_idx[IDX_W-1:0];
  assign rd_idx_full = rd_offset - CFG_BASE;
  assign ridx        = rd_idx_full[IDX_W-1:0];
  assign wbyte       = write_data[{dec.off[1:0], 3'b000} +: 8];
  assign cfg_wr      = en && dec.wr && dec.cfg_ok;
  assign word_wr     = en && dec.wr && dec.word_ok;
  assign poll_hit    = en && dec.poll && pend_r;

  // config byte memory, read when the item enters the input register
  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      cfg_mem[widx] <= wbyte;
    end
    if (rd_req) begin
      mem_q_r <= cfg_mem[ridx];
    end
  end

  // forward a write from the item ahead, and the reset value of unwritten bytes
  always_ff @(posedge clk) begin
    if (rd_req) begin
      byp_r      <= cfg_wr && (widx == ridx);
      byp_data_r <= wbyte;
      vld_hit_r  <= cfg_vld_r[ridx];
      rst_one_r  <= (CONFIG_BYTES > 2) && (rd_idx_full == 12'd2);
    end
  end

  // per-byte written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_vld_r <= '0;
    end else if (cfg_wr) begin
      cfg_vld_r[widx] <= 1'b1;
    end
  end

  assign cfg_byte = byp_r     ? byp_data_r :
                    vld_hit_r ? mem_q_r    : {7'd0, rst_one_r};

  // word register writes, notify capture and poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_feat_r   <= '0;
      qpfn_r       <= '0;
      dev_status_r <= '0;
      pend_r       <= 1'b0;
      int_status_r <= '0;
    end else begin
      if (word_wr) begin
        case (dec.off)
          REG_DRV_FEATURES: drv_feat_r   <= write_data;
          REG_QUEUE_PFN:    qpfn_r       <= write_data;
          REG_QUEUE_NOTIFY: pend_r       <= (write_data != '1);
          REG_INT_ACK:      int_status_r <= int_status_r & ~write_data[7:0];
          REG_STATUS:       dev_status_r <= write_data;
          default: ;
        endcase
      end
      if (poll_hit) begin
        int_status_r[0] <= 1'b1;
        pend_r          <= 1'b0;
      end
    end
  end

  // word register read select
  always_comb begin
    case (dec.off)
      REG_MAGIC:        word_rd = MAGIC_VALUE;
      REG_VERSION:      word_rd = VERSION_VALUE;
      REG_DEVICE_ID:    word_rd = DEVICE_ID;
      REG_VENDOR_ID:    word_rd = VENDOR_ID;
      REG_DEV_FEATURES: word_rd = '0;
      REG_DRV_FEATURES: word_rd = drv_feat_r;
      REG_QUEUE_MAX:    word_rd = VMBD_QUEUE_MAX;
      REG_QUEUE_PFN:    word_rd = qpfn_r;
      REG_INT_STATUS:   word_rd = {24'd0, int_status_r};
      REG_STATUS:       word_rd = dev_status_r;
      default:          word_rd = '0;
    endcase
  end

  assign read_data  = (dec.rd && dec.word_ok) ? word_rd :
                      (dec.rd && dec.cfg_ok)  ? {24'd0, cfg_byte} : '0;
  assign irq_raised = poll_hit;

  // a poll that finds a notify leaves it consumed and the interrupt bit set
  a_poll_consumes: assert property (@(posedge clk) disable iff (!rst_n)
    poll_hit |=> !pend_r && int_status_r[0])
    else $error("poll did not consume pending notify");

  // a notify with a real queue number is pending afterwards
  a_notify_pends: assert property (@(posedge clk) disable iff (!rst_n)
    word_wr && (dec.off == REG_QUEUE_NOTIFY) && (write_data != '1) |=> pend_r)
    else $error("notify write lost");

  // a faulting item changes no state
  a_fault_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    en && (dec.fault != FAULT_OK) |=>
      $stable(int_status_r) && $stable(pend_r) && $stable(dev_status_r) &&
      $stable(cfg_vld_r))
    else $error("faulting item updated state");

endmodule

// ===== design/virtio_mmio_block_device_registers_unit.sv =====
// Legacy virtio-mmio block device register unit: input register, decode, registers, result register.
// A result item passes from the input register to the result register and is held on out_ch until taken.
// Throughput: one item per cycle unless out_ch stalls; input and result registers form a two-stage pipeline.
// The config byte memory is read as an item enters the input register, with a forward path.
// Reset (synchronous, active low) clears the pipeline valid flags and the device registers; config byte two
// reads as one until written, tracked by a written flag per byte, so no clearing pass is needed.
`timescale 1ns / 1ps
module virtio_mmio_block_device_registers_unit import vmbd_pkg::*; #(
  parameter int CONFIG_BYTES = VMBD_CONFIG_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  vmbd_in_if.sink    in_ch,
  vmbd_out_if.source out_ch
);

  logic        s1_valid_r;
  logic [1:0]  s1_action_r;
  logic [11:0] s1_offset_r;
  logic [1:0]  s1_size_r;
  logic [31:0] s1_wdata_r;

  logic        out_valid_r;
  logic [31:0] out_rdata_r;
  logic [1:0]  out_fault_r;
  logic        out_irq_r;

  logic        adv;
  logic        in_ready;
  logic        accept;
  logic        en;
  vmbd_dec_t   dec;
  logic [31:0] rdata;
  logic        irq;

  // pipeline flow control
  assign adv      = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || adv;
  assign accept   = in_ch.valid && in_ready;
  assign en       = s1_valid_r && adv;

  assign in_ch.ready = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_ch.action;
      s1_offset_r <= in_ch.offset;
      s1_size_r   <= in_ch.access_size;
      s1_wdata_r  <= in_ch.write_data;
    end
  end

  vmbd_decode #(
    .CONFIG_BYTES (CONFIG_BYTES)
  ) u_decode (
    .action      (s1_action_r),
    .offset      (s1_offset_r),
    .access_size (s1_size_r),
    .dec         (dec)
  );

  vmbd_regs #(
    .CONFIG_BYTES (CONFIG_BYTES)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_req     (accept),
    .rd_offset  (in_ch.offset),
    .en         (en),
    .dec        (dec),
    .write_data (s1_wdata_r),
    .read_data  (rdata),
    .irq_raised (irq)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rdata_r <= rdata;
      out_fault_r <= dec.fault;
      out_irq_r   <= irq;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_rdata_r;
  assign out_ch.fault      = out_fault_r;
  assign out_ch.irq_raised = out_irq_r;

endmodule
